// File: hdl/windowed_load_pressure_classifier_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed load pressure classifier
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_LOAD_PRESSURE_CLASSIFIER_CORE_ASSERT_SVH
`define WINDOWED_LOAD_PRESSURE_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define WLPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WLPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/wlpc_pkg.sv
// ----------------------------------------------------------------------------
// wlpc_pkg
// Types, widths, register map and grading helpers of the load pressure
// classifier.
// ----------------------------------------------------------------------------
package wlpc_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int LVL_W      = 2;
	localparam int RATE_W     = 3;
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = 6;
	localparam int FILL_W     = 7;
	localparam int DIVIDEND_W = 16;
	localparam int DIVISOR_W  = 7;
	localparam int QUOT_W     = 10;
	localparam int QCNT_W     = 4;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 3;
	localparam int SAMPLE_MAX = 1023;

	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);

	localparam logic [REG_IDX_W-1:0] REG_CPU_ELEV = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CPU_HIGH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CPU_CRIT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MEM_ELEV = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MEM_HIGH = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MEM_CRIT = 3'd5;

	localparam logic [SAMPLE_W-1:0] RST_CPU_ELEV = 10'd600;
	localparam logic [SAMPLE_W-1:0] RST_CPU_HIGH = 10'd750;
	localparam logic [SAMPLE_W-1:0] RST_CPU_CRIT = 10'd850;
	localparam logic [SAMPLE_W-1:0] RST_MEM_ELEV = 10'd700;
	localparam logic [SAMPLE_W-1:0] RST_MEM_HIGH = 10'd800;
	localparam logic [SAMPLE_W-1:0] RST_MEM_CRIT = 10'd900;

	localparam logic [1:0] WSEL_SHORT = 2'd0;
	localparam logic [1:0] WSEL_MID   = 2'd1;
	localparam logic [1:0] WSEL_LONG  = 2'd2;
	localparam logic [1:0] EVICT_LAST = 2'd3;

	localparam logic [LVL_W-1:0] LVL_NORMAL   = 2'd0;
	localparam logic [LVL_W-1:0] LVL_ELEVATED = 2'd1;
	localparam logic [LVL_W-1:0] LVL_HIGH     = 2'd2;
	localparam logic [LVL_W-1:0] LVL_CRITICAL = 2'd3;

	localparam logic [RATE_W-1:0] RATE_FULL    = 3'd4;
	localparam logic [RATE_W-1:0] RATE_HALF    = 3'd2;
	localparam logic [RATE_W-1:0] RATE_QUARTER = 3'd1;
	localparam logic [RATE_W-1:0] RATE_NONE    = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] cpu_elev;
		logic [SAMPLE_W-1:0] cpu_high;
		logic [SAMPLE_W-1:0] cpu_crit;
		logic [SAMPLE_W-1:0] mem_elev;
		logic [SAMPLE_W-1:0] mem_high;
		logic [SAMPLE_W-1:0] mem_crit;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] avg_short;
		logic [SAMPLE_W-1:0] avg_mid;
		logic [SAMPLE_W-1:0] avg_long;
		logic [LVL_W-1:0]    pressure_level;
		logic                spawn_safe;
		logic [RATE_W-1:0]   spawn_rate_quarters;
	} res_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_sts_t;

	function automatic logic [LVL_W-1:0] grade(
		input logic [SAMPLE_W-1:0] v,
		input logic [SAMPLE_W-1:0] elev,
		input logic [SAMPLE_W-1:0] high,
		input logic [SAMPLE_W-1:0] crit
	);
		logic [LVL_W-1:0] lvl;
		priority if (v >= crit) lvl = LVL_CRITICAL;
		else if (v >= high)     lvl = LVL_HIGH;
		else if (v >= elev)     lvl = LVL_ELEVATED;
		else                    lvl = LVL_NORMAL;
		return lvl;
	endfunction

	function automatic logic [RATE_W-1:0] rate_of(input logic [LVL_W-1:0] lvl);
		logic [RATE_W-1:0] rate;
		unique case (lvl)
			LVL_NORMAL:   rate = RATE_FULL;
			LVL_ELEVATED: rate = RATE_HALF;
			LVL_HIGH:     rate = RATE_QUARTER;
			default:      rate = RATE_NONE;
		endcase
		return rate;
	endfunction

endpackage

// File: hdl/wlpc_if.sv
// ----------------------------------------------------------------------------
// wlpc_in_if / wlpc_out_if
// Valid/ready channels for samples in and classification results out.
// ----------------------------------------------------------------------------
interface wlpc_in_if;
	import wlpc_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] cpu_sample;
	logic [SAMPLE_W-1:0] mem_sample;

	modport source (output valid, output cpu_sample, output mem_sample, input ready);
	modport sink   (input valid, input cpu_sample, input mem_sample, output ready);
endinterface

interface wlpc_out_if;
	import wlpc_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] avg_short;
	logic [SAMPLE_W-1:0] avg_mid;
	logic [SAMPLE_W-1:0] avg_long;
	logic [LVL_W-1:0]    pressure_level;
	logic                spawn_safe;
	logic [RATE_W-1:0]   spawn_rate_quarters;

	modport source (
		output valid, output avg_short, output avg_mid, output avg_long,
		output pressure_level, output spawn_safe, output spawn_rate_quarters,
		input ready
	);
	modport sink (
		input valid, input avg_short, input avg_mid, input avg_long,
		input pressure_level, input spawn_safe, input spawn_rate_quarters,
		output ready
	);
endinterface

// File: hdl/wlpc_ring.sv
// ----------------------------------------------------------------------------
// wlpc_ring
// Sample ring: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wlpc_ring (
	input  logic                          clk,
	input  logic                          we,
	input  logic [wlpc_pkg::RING_AW-1:0]  waddr,
	input  logic [wlpc_pkg::SAMPLE_W-1:0] wdata,
	input  logic [wlpc_pkg::RING_AW-1:0]  raddr,
	output logic [wlpc_pkg::SAMPLE_W-1:0] rdata
);
	import wlpc_pkg::*;

	logic [SAMPLE_W-1:0] ring_q [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ring_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_q[raddr];
	end

	assign rdata = rd_q;

endmodule

// File: hdl/wlpc_div.sv
// ----------------------------------------------------------------------------
// wlpc_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit QUOT_W bits, so the upper dividend bits preload the remainder.
// ----------------------------------------------------------------------------
module wlpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wlpc_pkg::div_req_t req,
	output wlpc_pkg::div_sts_t sts
);
	import wlpc_pkg::*;

	localparam logic [QCNT_W-1:0] CNT_LAST = QCNT_W'(QUOT_W - 1);

	logic                 busy_q;
	logic [QCNT_W-1:0]    cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [QUOT_W-1:0]    shr_q;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, shr_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIVISOR_W'(req.dividend[DIVIDEND_W-1:QUOT_W]);
			shr_q <= req.dividend[QUOT_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			shr_q <= {shr_q[QUOT_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == CNT_LAST);
	assign sts.quot = {shr_q[QUOT_W-2:0], ge};

endmodule

// File: hdl/wlpc_cfg.sv
// ----------------------------------------------------------------------------
// wlpc_cfg
// APB threshold registers for CPU and memory pressure grading.
// ----------------------------------------------------------------------------
module wlpc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wlpc_pkg::PADDR_W-1:0] paddr,
	input  logic [wlpc_pkg::PDATA_W-1:0] pwdata,
	output logic [wlpc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output wlpc_pkg::cfg_t               cfg
);
	import wlpc_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic [SAMPLE_W-1:0]  wval;
	logic                 wr;

	assign idx    = paddr[PADDR_W-1:2];
	assign wval   = pwdata[SAMPLE_W-1:0];
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpu_elev <= RST_CPU_ELEV;
			cfg_q.cpu_high <= RST_CPU_HIGH;
			cfg_q.cpu_crit <= RST_CPU_CRIT;
			cfg_q.mem_elev <= RST_MEM_ELEV;
			cfg_q.mem_high <= RST_MEM_HIGH;
			cfg_q.mem_crit <= RST_MEM_CRIT;
		end else if (wr) begin
			unique case (idx)
				REG_CPU_ELEV: cfg_q.cpu_elev <= wval;
				REG_CPU_HIGH: cfg_q.cpu_high <= wval;
				REG_CPU_CRIT: cfg_q.cpu_crit <= wval;
				REG_MEM_ELEV: cfg_q.mem_elev <= wval;
				REG_MEM_HIGH: cfg_q.mem_high <= wval;
				REG_MEM_CRIT: cfg_q.mem_crit <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CPU_ELEV: prdata = PDATA_W'(cfg_q.cpu_elev);
			REG_CPU_HIGH: prdata = PDATA_W'(cfg_q.cpu_high);
			REG_CPU_CRIT: prdata = PDATA_W'(cfg_q.cpu_crit);
			REG_MEM_ELEV: prdata = PDATA_W'(cfg_q.mem_elev);
			REG_MEM_HIGH: prdata = PDATA_W'(cfg_q.mem_high);
			REG_MEM_CRIT: prdata = PDATA_W'(cfg_q.mem_crit);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/windowed_load_pressure_classifier_core.sv
// ----------------------------------------------------------------------------
// windowed_load_pressure_classifier_core
// Sliding-window CPU load averages with threshold grading of CPU and memory.
// ----------------------------------------------------------------------------
// Usage:
//   sample (valid/ready): one CPU sample and one memory sample per transfer.
//   result (valid/ready): three window averages of the CPU samples, the
//     pressure level, the spawn-safe flag and the spawn rate in quarters.
//   APB port: six 10-bit thresholds at byte addresses 0, 4, ... 20.
// Sequence: a sample runs through the ring-update steps and three
//   divisions on one shared radix-2 divider, then it is graded.
//   sample.ready is high only while the sequencer is idle, so a new sample
//   is taken only once the last result has gone to the output register.
// Stall: the result waits in an output register; the next sample is taken
//   and processed meanwhile, and its result holds in the sequencer until
//   the output register is free.
// Reset: windows empty, sums zero, thresholds at their defaults. The ring
//   needs no clearing: an entry is read only after it was written.
// ----------------------------------------------------------------------------
`include "windowed_load_pressure_classifier_core_assert.svh"

module windowed_load_pressure_classifier_core #(
	parameter int WINDOW_SHORT = 5,
	parameter int WINDOW_MID   = 30,
	parameter int WINDOW_LONG  = 60
) (
	input  logic                         clk,
	input  logic                         arst_n,
	wlpc_in_if.sink                      sample,
	wlpc_out_if.source                   result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wlpc_pkg::PADDR_W-1:0] paddr,
	input  logic [wlpc_pkg::PDATA_W-1:0] pwdata,
	output logic [wlpc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import wlpc_pkg::*;

	localparam int WS = (WINDOW_SHORT < 1) ? 1 :
		(WINDOW_SHORT > RING_DEPTH) ? RING_DEPTH : WINDOW_SHORT;
	localparam int WM = (WINDOW_MID < 1) ? 1 :
		(WINDOW_MID > RING_DEPTH) ? RING_DEPTH : WINDOW_MID;
	localparam int WL = (WINDOW_LONG < 1) ? 1 :
		(WINDOW_LONG > RING_DEPTH) ? RING_DEPTH : WINDOW_LONG;

	localparam int SW_S = $clog2(WS * SAMPLE_MAX + 1);
	localparam int SW_M = $clog2(WM * SAMPLE_MAX + 1);
	localparam int SW_L = $clog2(WL * SAMPLE_MAX + 1);
	localparam int SUMX_W = DIVIDEND_W + 1;

	localparam logic [FILL_W-1:0] W_SHORT = FILL_W'(WS);
	localparam logic [FILL_W-1:0] W_MID   = FILL_W'(WM);
	localparam logic [FILL_W-1:0] W_LONG  = FILL_W'(WL);

	function automatic logic [FILL_W-1:0] win_of(input logic [1:0] sel);
		logic [FILL_W-1:0] w;
		unique case (sel)
			WSEL_SHORT: w = W_SHORT;
			WSEL_MID:   w = W_MID;
			default:    w = W_LONG;
		endcase
		return w;
	endfunction

	state_t              state_q, state_d;
	logic [1:0]          idx_q;
	logic [1:0]          sel_q;
	logic [SAMPLE_W-1:0] cpu_q;
	logic [SAMPLE_W-1:0] mem_q;
	logic [FILL_W-1:0]   seen_q;
	logic [RING_AW-1:0]  wslot_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SW_S-1:0]     sum_s_q;
	logic [SW_M-1:0]     sum_m_q;
	logic [SW_L-1:0]     sum_l_q;
	logic [SAMPLE_W-1:0] avg_s_q;
	logic [SAMPLE_W-1:0] avg_m_q;
	logic [SAMPLE_W-1:0] avg_l_q;
	res_t                res_q;
	logic                out_valid_q;

	logic                  in_rdy;
	logic                  accept;
	logic                  out_free;
	logic                  load_out;
	logic                  apply_ev;
	logic                  ring_we;
	logic                  div_start;
	logic [RING_AW-1:0]    ring_raddr;
	logic [SAMPLE_W-1:0]   ring_rdata;
	logic [FILL_W-1:0]     w_rd;
	logic [1:0]            ev_sel;
	logic [FILL_W-1:0]     w_ev;
	logic                  evict;
	logic [DIVIDEND_W-1:0] ev_sum;
	logic [SUMX_W-1:0]     upd_sum;
	logic [FILL_W-1:0]     w_dv;
	logic [DIVIDEND_W-1:0] dv_sum;
	div_req_t              div_req;
	div_sts_t              div_sts;
	cfg_t                  cfg;
	logic [LVL_W-1:0]      cpu_lvl;
	logic [LVL_W-1:0]      mem_lvl;
	logic [LVL_W-1:0]      lvl;
	res_t                  res_d;

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_d = ST_EVICT;
			end
			ST_EVICT: begin
				if (idx_q == EVICT_LAST) state_d = ST_DIV_START;
			end
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_sts.done) state_d = (sel_q == WSEL_LONG) ? ST_FINISH : ST_DIV_START;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_rdy    = 1'b0;
		apply_ev  = 1'b0;
		ring_we   = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:      in_rdy = 1'b1;
			ST_EVICT: begin
				apply_ev = (idx_q != WSEL_SHORT);
				ring_we  = (idx_q == EVICT_LAST);
			end
			ST_DIV_START: div_start = 1'b1;
			ST_DIV_WAIT:  ;
			ST_FINISH:    load_out = out_free;
			default:      ;
		endcase
	end

	assign sample.ready = in_rdy;

	// eviction: read issued at idx, data applied at idx + 1
	assign w_rd       = win_of(idx_q);
	assign ring_raddr = wslot_q - w_rd[RING_AW-1:0];
	assign ev_sel     = idx_q - 2'd1;
	assign w_ev       = win_of(ev_sel);
	assign evict      = seen_q >= w_ev;

	always_comb begin
		unique case (ev_sel)
			WSEL_SHORT: ev_sum = DIVIDEND_W'(sum_s_q);
			WSEL_MID:   ev_sum = DIVIDEND_W'(sum_m_q);
			default:    ev_sum = DIVIDEND_W'(sum_l_q);
		endcase
	end

	assign upd_sum = SUMX_W'(ev_sum) + SUMX_W'(cpu_q)
		- (evict ? SUMX_W'(ring_rdata) : SUMX_W'(0));

	// divider operands
	assign w_dv = win_of(sel_q);

	always_comb begin
		unique case (sel_q)
			WSEL_SHORT: dv_sum = DIVIDEND_W'(sum_s_q);
			WSEL_MID:   dv_sum = DIVIDEND_W'(sum_m_q);
			default:    dv_sum = DIVIDEND_W'(sum_l_q);
		endcase
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = dv_sum;
	assign div_req.divisor  = (fill_q < w_dv) ? fill_q : w_dv;

	// grading
	assign cpu_lvl = grade(avg_m_q, cfg.cpu_elev, cfg.cpu_high, cfg.cpu_crit);
	assign mem_lvl = grade(mem_q, cfg.mem_elev, cfg.mem_high, cfg.mem_crit);
	assign lvl     = (cpu_lvl > mem_lvl) ? cpu_lvl : mem_lvl;

	assign res_d.avg_short           = avg_s_q;
	assign res_d.avg_mid             = avg_m_q;
	assign res_d.avg_long            = avg_l_q;
	assign res_d.pressure_level      = lvl;
	assign res_d.spawn_safe          = (lvl != LVL_CRITICAL);
	assign res_d.spawn_rate_quarters = rate_of(lvl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			sel_q       <= '0;
			wslot_q     <= '0;
			fill_q      <= '0;
			sum_s_q     <= '0;
			sum_m_q     <= '0;
			sum_l_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= WSEL_SHORT;
			end else if (state_q == ST_EVICT) begin
				idx_q <= idx_q + 2'd1;
			end
			if (apply_ev) begin
				unique case (ev_sel)
					WSEL_SHORT: sum_s_q <= upd_sum[SW_S-1:0];
					WSEL_MID:   sum_m_q <= upd_sum[SW_M-1:0];
					default:    sum_l_q <= upd_sum[SW_L-1:0];
				endcase
			end
			if (ring_we) begin
				wslot_q <= wslot_q + 1'b1;
				if (fill_q < FILL_MAX) fill_q <= fill_q + 1'b1;
				sel_q <= WSEL_SHORT;
			end else if (state_q == ST_DIV_WAIT && div_sts.done) begin
				sel_q <= sel_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q  <= sample.cpu_sample;
			mem_q  <= sample.mem_sample;
			seen_q <= fill_q;
		end
		if (state_q == ST_DIV_WAIT && div_sts.done) begin
			unique case (sel_q)
				WSEL_SHORT: avg_s_q <= div_sts.quot;
				WSEL_MID:   avg_m_q <= div_sts.quot;
				default:    avg_l_q <= div_sts.quot;
			endcase
		end
		if (load_out) begin
			res_q <= res_d;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.avg_short           = res_q.avg_short;
	assign result.avg_mid             = res_q.avg_mid;
	assign result.avg_long            = res_q.avg_long;
	assign result.pressure_level      = res_q.pressure_level;
	assign result.spawn_safe          = res_q.spawn_safe;
	assign result.spawn_rate_quarters = res_q.spawn_rate_quarters;

	wlpc_ring u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wslot_q),
		.wdata (cpu_q),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	wlpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	wlpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	`WLPC_ASSERT_IMP(a_div_start_idle, div_start, !div_sts.busy, "divider started while busy")
	`WLPC_ASSERT_NXT(a_accept_evict, accept, state_q == ST_EVICT && idx_q == WSEL_SHORT, "no evict")
	`WLPC_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_MAX, "fill count beyond ring depth")
	`WLPC_ASSERT_IMP(a_out_load, $rose(out_valid_q), $past(state_q) == ST_FINISH, "stray result")
	`WLPC_ASSERT_IMP(a_busy_no_ready, div_sts.busy, !sample.ready, "sample taken during division")

endmodule

// File: test/windowed_load_pressure_classifier_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_load_pressure_classifier_core_tb
// Drives CPU/memory sample pairs through the classifier and checks every
// result against a typed table value or an in-bench predictor of the window
// sums, averages and pressure grading. A short directed table runs first,
// then random phases under several threshold settings, with random idling
// on both channels and one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module windowed_load_pressure_classifier_core_tb;
	import wlpc_pkg::*;

	localparam int SHORT_LEN      = 5;
	localparam int MID_LEN        = 30;
	localparam int LONG_LEN       = 60;
	localparam int NUM_THRESHOLDS = 6;
	localparam int DIR_ROWS       = 20;
	localparam int HOLD_AFTER     = 250;
	localparam int HOLD_CYCLES    = 600;
	localparam int PRINT_CAP      = 50;
	localparam int PEND_DEPTH     = 16;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [SAMPLE_W-1:0] cpu;
		logic [SAMPLE_W-1:0] mem;
		logic                typed;
		res_t                want;
	} load_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	wlpc_in_if  sample_ch ();
	wlpc_out_if result_ch ();

	windowed_load_pressure_classifier_core #(
		.WINDOW_SHORT(SHORT_LEN),
		.WINDOW_MID  (MID_LEN),
		.WINDOW_LONG (LONG_LEN)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.result (result_ch.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// predictor state
	logic [SAMPLE_W-1:0] cpu_hist [RING_DEPTH];
	int unsigned         hist_wr;
	int unsigned         hist_fill;
	int unsigned         sum_short;
	int unsigned         sum_mid;
	int unsigned         sum_long;
	logic [SAMPLE_W-1:0] thr [8] = '{RST_CPU_ELEV, RST_CPU_HIGH, RST_CPU_CRIT,
		RST_MEM_ELEV, RST_MEM_HIGH, RST_MEM_CRIT, 10'd0, 10'd0};

	res_t pending_res [PEND_DEPTH];
	int   pend_wr;
	int   pend_rd;
	int   class_mismatches;
	int   results_seen;
	bit   sender_burst;
	int   cpu_base;

	load_row_t dir_rows [DIR_ROWS] = '{
		'{10'd0,    10'd0,    1'b1, '{10'd0, 10'd0, 10'd0, LVL_NORMAL, 1'b1, RATE_FULL}},
		'{10'd1023, 10'd1023, 1'b1,
			'{10'd511, 10'd511, 10'd511, LVL_CRITICAL, 1'b0, RATE_NONE}},
		'{10'd1000, 10'd899,  1'b0, '0},
		'{10'd1000, 10'd900,  1'b0, '0},
		'{10'd1001, 10'd699,  1'b0, '0},
		'{10'd512,  10'd700,  1'b0, '0},
		'{10'd341,  10'd799,  1'b0, '0},
		'{10'd682,  10'd800,  1'b0, '0},
		'{10'd0,    10'd0,    1'b0, '0},
		'{10'd1023, 10'd0,    1'b0, '0},
		'{10'd600,  10'd1023, 1'b0, '0},
		'{10'd750,  10'd1,    1'b0, '0},
		'{10'd850,  10'd2,    1'b0, '0},
		'{10'd0,    10'd512,  1'b0, '0},
		'{10'd1022, 10'd256,  1'b0, '0},
		'{10'd1,    10'd128,  1'b0, '0},
		'{10'd1000, 10'd64,   1'b0, '0},
		'{10'd999,  10'd32,   1'b0, '0},
		'{10'd598,  10'd16,   1'b0, '0},
		'{10'd601,  10'd1000, 1'b0, '0}
	};

	function automatic int unsigned slide_window(input int unsigned sum, input int w,
		input logic [SAMPLE_W-1:0] cpu, input int unsigned seen);
		if (seen >= w)
			sum -= cpu_hist[(hist_wr + RING_DEPTH - w) % RING_DEPTH];
		return sum + cpu;
	endfunction

	function automatic logic [SAMPLE_W-1:0] window_mean(input int unsigned sum, input int w);
		int unsigned n;
		n = (hist_fill < w) ? hist_fill : w;
		if (n == 0)
			return '0;
		return SAMPLE_W'(sum / n);
	endfunction

	function automatic logic [LVL_W-1:0] grade_of(input logic [SAMPLE_W-1:0] v,
		input logic [SAMPLE_W-1:0] elev, input logic [SAMPLE_W-1:0] high,
		input logic [SAMPLE_W-1:0] crit);
		if (v >= crit)
			return LVL_CRITICAL;
		if (v >= high)
			return LVL_HIGH;
		if (v >= elev)
			return LVL_ELEVATED;
		return LVL_NORMAL;
	endfunction

	function automatic res_t classify_load(input logic [SAMPLE_W-1:0] cpu,
		input logic [SAMPLE_W-1:0] mem);
		res_t             r;
		int unsigned      seen;
		logic [LVL_W-1:0] lvl_cpu;
		logic [LVL_W-1:0] lvl_mem;
		logic [LVL_W-1:0] lvl;
		seen = hist_fill;
		sum_short = slide_window(sum_short, SHORT_LEN, cpu, seen);
		sum_mid   = slide_window(sum_mid, MID_LEN, cpu, seen);
		sum_long  = slide_window(sum_long, LONG_LEN, cpu, seen);
		cpu_hist[hist_wr] = cpu;
		hist_wr = (hist_wr + 1) % RING_DEPTH;
		if (hist_fill < RING_DEPTH)
			hist_fill++;
		r.avg_short = window_mean(sum_short, SHORT_LEN);
		r.avg_mid   = window_mean(sum_mid, MID_LEN);
		r.avg_long  = window_mean(sum_long, LONG_LEN);
		lvl_cpu = grade_of(r.avg_mid, thr[REG_CPU_ELEV], thr[REG_CPU_HIGH], thr[REG_CPU_CRIT]);
		lvl_mem = grade_of(mem, thr[REG_MEM_ELEV], thr[REG_MEM_HIGH], thr[REG_MEM_CRIT]);
		lvl = (lvl_cpu > lvl_mem) ? lvl_cpu : lvl_mem;
		r.pressure_level = lvl;
		r.spawn_safe     = (lvl != LVL_CRITICAL);
		case (lvl)
			LVL_NORMAL:   r.spawn_rate_quarters = RATE_FULL;
			LVL_ELEVATED: r.spawn_rate_quarters = RATE_HALF;
			LVL_HIGH:     r.spawn_rate_quarters = RATE_QUARTER;
			default:      r.spawn_rate_quarters = RATE_NONE;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [SAMPLE_W-1:0] clip_sample(input int v);
		if (v < 0)
			return '0;
		if (v > SAMPLE_MAX)
			return SAMPLE_W'(SAMPLE_MAX);
		return SAMPLE_W'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		class_mismatches++;
		if (class_mismatches <= PRINT_CAP)
			$display("%0t: MISMATCH %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic write_threshold(input logic [REG_IDX_W-1:0] idx,
		input logic [SAMPLE_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {22'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx < NUM_THRESHOLDS)
			thr[idx] = val;
	endtask

	task automatic set_thresholds(input int ce, input int ch, input int cc,
		input int me, input int mh, input int mc);
		write_threshold(REG_CPU_ELEV, SAMPLE_W'(ce));
		write_threshold(REG_CPU_HIGH, SAMPLE_W'(ch));
		write_threshold(REG_CPU_CRIT, SAMPLE_W'(cc));
		write_threshold(REG_MEM_ELEV, SAMPLE_W'(me));
		write_threshold(REG_MEM_HIGH, SAMPLE_W'(mh));
		write_threshold(REG_MEM_CRIT, SAMPLE_W'(mc));
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_load(input logic [SAMPLE_W-1:0] cpu, input logic [SAMPLE_W-1:0] mem,
		input logic typed, input res_t want);
		res_t pred;
		int   gap;
		sample_ch.valid      <= 1'b1;
		sample_ch.cpu_sample <= cpu;
		sample_ch.mem_sample <= mem;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pred = classify_load(cpu, mem);
		pending_res[pend_wr % PEND_DEPTH] = typed ? want : pred;
		pend_wr++;
		gap = sender_burst ? 0 : pick_gap();
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_random(input int count);
		int r;
		int pick;
		logic [SAMPLE_W-1:0] cpu;
		logic [SAMPLE_W-1:0] mem;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				sender_burst = !sender_burst;
			r = $urandom_range(0, 99);
			if (r < 2)
				cpu_base = thr[REG_CPU_ELEV + $urandom_range(0, 2)];
			else if (r < 3)
				cpu_base = $urandom_range(0, SAMPLE_MAX);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				cpu = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			else if (pick < 13)
				cpu = pick[0] ? SAMPLE_W'(SAMPLE_MAX) : '0;
			else
				cpu = clip_sample(cpu_base + int'($urandom_range(0, 40)) - 20);
			if ($urandom_range(0, 99) < 30)
				mem = clip_sample(int'(thr[REG_MEM_ELEV + $urandom_range(0, 2)])
					+ int'($urandom_range(0, 2)) - 1);
			else
				mem = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			send_load(cpu, mem, 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("windowed_load_pressure_classifier_core verification failed");
		$finish;
	end

	// result sink: random stalls, eager stretches, one long hold-off
	initial begin
		int  stall_left;
		int  cycle;
		bit  eager;
		bit  held;
		stall_left = 0;
		cycle      = 0;
		eager      = 1'b0;
		held       = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 256 == 0)
				eager = ($urandom_range(0, 3) == 0);
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				stall_left = HOLD_CYCLES;
			end else begin
				result_ch.ready <= 1'b1;
				if (!eager)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pend_wr == pend_rd) begin
				report_mismatch("result transfer with nothing pending");
			end else begin
				want = pending_res[pend_rd % PEND_DEPTH];
				pend_rd++;
				check_field("avg_short", result_ch.avg_short, want.avg_short);
				check_field("avg_mid", result_ch.avg_mid, want.avg_mid);
				check_field("avg_long", result_ch.avg_long, want.avg_long);
				check_field("pressure_level", result_ch.pressure_level, want.pressure_level);
				check_field("spawn_safe", result_ch.spawn_safe, want.spawn_safe);
				check_field("spawn_rate_quarters", result_ch.spawn_rate_quarters,
					want.spawn_rate_quarters);
			end
		end
	end

	initial begin
		int lv [6];
		int tmp;
		class_mismatches = 0;
		results_seen     = 0;
		pend_wr          = 0;
		pend_rd          = 0;
		sender_burst     = 1'b0;
		cpu_base         = 500;
		hist_wr          = 0;
		hist_fill        = 0;
		sum_short        = 0;
		sum_mid          = 0;
		sum_long         = 0;
		foreach (cpu_hist[i])
			cpu_hist[i] = '0;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.cpu_sample = '0;
		sample_ch.mem_sample = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_load(dir_rows[i].cpu, dir_rows[i].mem, dir_rows[i].typed, dir_rows[i].want);

		// everything at or above zero: always critical
		drain();
		set_thresholds(0, 0, 0, 0, 0, 0);
		run_random(100);

		// only full-scale values reach any grade
		drain();
		set_thresholds(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		run_random(100);

		// grades out of order, plus writes to unmapped addresses
		drain();
		write_threshold(REG_SPARE_A, SAMPLE_W'($urandom()));
		write_threshold(REG_SPARE_B, SAMPLE_W'($urandom()));
		set_thresholds(900, 300, 600, 1000, 200, 650);
		run_random(150);

		repeat (2) begin
			drain();
			foreach (lv[k])
				lv[k] = $urandom_range(0, SAMPLE_MAX);
			// order the CPU levels
			if (lv[0] > lv[1]) begin
				tmp = lv[0]; lv[0] = lv[1]; lv[1] = tmp;
			end
			if (lv[1] > lv[2]) begin
				tmp = lv[1]; lv[1] = lv[2]; lv[2] = tmp;
			end
			if (lv[0] > lv[1]) begin
				tmp = lv[0]; lv[0] = lv[1]; lv[1] = tmp;
			end
			set_thresholds(lv[0], lv[1], lv[2], lv[3], lv[4], lv[5]);
			run_random(200);
		end

		drain();
		set_thresholds(RST_CPU_ELEV, RST_CPU_HIGH, RST_CPU_CRIT,
			RST_MEM_ELEV, RST_MEM_HIGH, RST_MEM_CRIT);
		run_random(200);

		drain();
		repeat (50) @(posedge clk);
		if (class_mismatches == 0)
			$display("windowed_load_pressure_classifier_core verification clean");
		else
			$display("windowed_load_pressure_classifier_core verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/wlpc_pkg.sv
hdl/wlpc_if.sv
hdl/wlpc_ring.sv
hdl/wlpc_div.sv
hdl/wlpc_cfg.sv
hdl/windowed_load_pressure_classifier_core.sv
test/windowed_load_pressure_classifier_core_tb.sv
